// File: sv/shdl_pkg.sv
// Types, character codes and keyword tables for the shader header directive locator.
package shdl_pkg;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_E     = 8'h65;

  localparam logic [3:0] VERSION_LEN   = 4'd7;
  localparam logic [3:0] EXTENSION_LEN = 4'd9;

  typedef enum logic [2:0] {
    M_NORMAL,
    M_SLASH,
    M_LINECOM,
    M_BLOCK,
    M_BLOCKSTAR,
    M_HASHWS,
    M_KEYWORD,
    M_LINESKIP
  } scan_mode_t;

  typedef enum logic [1:0] {
    K_NONE,
    K_VERSION,
    K_EXTENSION
  } kw_kind_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
  } text_item_t;

  typedef struct packed {
    logic        version_found;
    logic [15:0] version_pos;
    logic        extension_found;
    logic [15:0] extension_pos;
    logic        body_found;
    logic [15:0] body_pos;
    logic [15:0] head_lines;
    logic        too_long;
  } result_item_t;

  function automatic logic [7:0] kw_char(input logic is_version, input logic [3:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (is_version) begin
      case (idx)
        4'd0: ch = "v";
        4'd1: ch = "e";
        4'd2: ch = "r";
        4'd3: ch = "s";
        4'd4: ch = "i";
        4'd5: ch = "o";
        4'd6: ch = "n";
        default: ch = 8'h00;
      endcase
    end else begin
      case (idx)
        4'd0: ch = "e";
        4'd1: ch = "x";
        4'd2: ch = "t";
        4'd3: ch = "e";
        4'd4: ch = "n";
        4'd5: ch = "s";
        4'd6: ch = "i";
        4'd7: ch = "o";
        4'd8: ch = "n";
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

endpackage

// File: sv/shdl_stream_if.sv
// Valid/ready stream interface carrying one request payload.
interface shdl_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/shdl_scanner.sv
// Directive scanner: scan state, offsets and counters updated once per byte.
module shdl_scanner #(
  parameter int MAX_TEXT = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  shdl_pkg::text_item_t item,
  output shdl_pkg::result_item_t res
);
  import shdl_pkg::*;

  localparam int OFS_W  = $clog2(MAX_TEXT + 1);
  localparam int WIDE_W = (OFS_W + 1 > 17) ? OFS_W + 1 : 17;

  scan_mode_t       mode, mode_next;
  kw_kind_t         kind, kind_next;
  logic [3:0]       kw_idx, kw_idx_next;
  logic [OFS_W-1:0] byte_offset, byte_offset_next;
  logic [15:0]      nl, nl_next;
  logic [15:0]      hash_ofs, hash_ofs_next;
  logic             ver_seen, ver_seen_next;
  logic [15:0]      ver_ofs, ver_ofs_next;
  logic             ext_seen, ext_seen_next;
  logic [15:0]      ext_ofs, ext_ofs_next;
  logic             body_seen, body_seen_next;
  logic [15:0]      body_ofs, body_ofs_next;
  logic [15:0]      body_lines, body_lines_next;
  logic             ovf, ovf_next;

  logic [7:0]        ch;
  logic              last;
  logic              is_slash, is_hash, is_star, is_lf, is_blank;
  logic              at_max;
  logic [WIDE_W-1:0] pos_w, pos1_w;
  logic [15:0]       pos_sat, pos1_sat;
  logic [3:0]        kw_len;
  logic              kw_match, kw_done;
  logic              record, mark;

  function automatic logic [15:0] sat16(input logic [WIDE_W-1:0] v);
    return (v > WIDE_W'(16'hFFFF)) ? 16'hFFFF : v[15:0];
  endfunction

  assign ch       = item.char_byte;
  assign last     = item.last_byte;
  assign is_slash = (ch == CH_SLASH);
  assign is_hash  = (ch == CH_HASH);
  assign is_star  = (ch == CH_STAR);
  assign is_lf    = (ch == CH_LF);
  assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB);
  assign at_max   = (byte_offset == OFS_W'(MAX_TEXT));
  assign pos_w    = WIDE_W'(byte_offset);
  assign pos1_w   = pos_w + WIDE_W'(1);
  assign pos_sat  = sat16(pos_w);
  assign pos1_sat = sat16(pos1_w);
  assign kw_len   = (kind == K_VERSION) ? VERSION_LEN : EXTENSION_LEN;
  assign kw_match = (kw_idx < kw_len) && (ch == kw_char(kind == K_VERSION, kw_idx));
  assign kw_done  = kw_match && ((kw_idx + 4'd1) == kw_len);

  always_comb begin
    mode_next = mode;
    case (mode)
      M_NORMAL: begin
        if (is_slash) mode_next = M_SLASH;
        else if (is_hash) mode_next = M_HASHWS;
      end
      M_SLASH: begin
        if (is_slash) mode_next = M_LINECOM;
        else if (is_star) mode_next = M_BLOCK;
        else if (is_hash) mode_next = M_HASHWS;
        else mode_next = M_NORMAL;
      end
      M_LINECOM: begin
        if (is_lf) mode_next = M_NORMAL;
      end
      M_BLOCK: begin
        if (is_star) mode_next = M_BLOCKSTAR;
      end
      M_BLOCKSTAR: begin
        if (is_slash) mode_next = M_NORMAL;
        else if (!is_star) mode_next = M_BLOCK;
      end
      M_HASHWS: begin
        if (is_blank) mode_next = M_HASHWS;
        else if (ch == CH_V || ch == CH_E) mode_next = M_KEYWORD;
        else mode_next = M_NORMAL;
      end
      M_KEYWORD: begin
        if (kw_match) begin
          if (kw_done) mode_next = last ? M_NORMAL : M_LINESKIP;
        end else if (is_slash) begin
          mode_next = M_SLASH;
        end else if (is_hash) begin
          mode_next = M_HASHWS;
        end else begin
          mode_next = M_NORMAL;
        end
      end
      M_LINESKIP: begin
        if (is_lf) mode_next = M_NORMAL;
      end
      default: mode_next = M_NORMAL;
    endcase
  end

  always_comb begin
    record = (mode == M_KEYWORD) && kw_done && !last;
    mark   = ((mode == M_LINESKIP) && is_lf) || (last && (mode_next == M_LINESKIP));

    byte_offset_next = at_max ? byte_offset : byte_offset + OFS_W'(1);
    ovf_next         = ovf | at_max;
    nl_next          = (is_lf && nl != 16'hFFFF) ? nl + 16'd1 : nl;
    hash_ofs_next    = (mode_next == M_HASHWS && mode != M_HASHWS) ? pos_sat : hash_ofs;

    kind_next   = kind;
    kw_idx_next = kw_idx;
    if (mode == M_HASHWS && !is_blank) begin
      if (ch == CH_V) begin
        kind_next   = K_VERSION;
        kw_idx_next = 4'd1;
      end else if (ch == CH_E) begin
        kind_next   = K_EXTENSION;
        kw_idx_next = 4'd1;
      end
    end else if (mode == M_KEYWORD) begin
      if (kw_match && !kw_done) begin
        kw_idx_next = kw_idx + 4'd1;
      end else begin
        kw_idx_next = 4'd0;
        kind_next   = K_NONE;
      end
    end

    ver_seen_next = ver_seen;
    ver_ofs_next  = ver_ofs;
    ext_seen_next = ext_seen;
    ext_ofs_next  = ext_ofs;
    if (record) begin
      if (kind == K_VERSION) begin
        ver_seen_next = 1'b1;
        ver_ofs_next  = hash_ofs;
      end else if (!ext_seen) begin
        ext_seen_next = 1'b1;
        ext_ofs_next  = hash_ofs;
      end
    end

    body_seen_next  = body_seen;
    body_ofs_next   = body_ofs;
    body_lines_next = body_lines;
    if (mark) begin
      body_seen_next  = 1'b1;
      body_ofs_next   = pos1_sat;
      body_lines_next = nl_next;
    end
  end

  always_comb begin
    res.version_found   = ver_seen_next;
    res.version_pos     = ver_seen_next ? ver_ofs_next : 16'd0;
    res.extension_found = ext_seen_next;
    res.extension_pos   = ext_seen_next ? ext_ofs_next : 16'd0;
    res.body_found      = body_seen_next;
    res.body_pos        = body_seen_next ? body_ofs_next : 16'd0;
    res.head_lines      = body_seen_next ? body_lines_next : 16'd0;
    res.too_long        = ovf_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      mode        <= M_NORMAL;
      kind        <= K_NONE;
      kw_idx      <= 4'd0;
      byte_offset <= '0;
      nl          <= 16'd0;
      hash_ofs    <= 16'd0;
      ver_seen    <= 1'b0;
      ver_ofs     <= 16'd0;
      ext_seen    <= 1'b0;
      ext_ofs     <= 16'd0;
      body_seen   <= 1'b0;
      body_ofs    <= 16'd0;
      body_lines  <= 16'd0;
      ovf         <= 1'b0;
    end else if (step) begin
      mode        <= mode_next;
      kind        <= kind_next;
      kw_idx      <= kw_idx_next;
      byte_offset <= byte_offset_next;
      nl          <= nl_next;
      hash_ofs    <= hash_ofs_next;
      ver_seen    <= ver_seen_next;
      ver_ofs     <= ver_ofs_next;
      ext_seen    <= ext_seen_next;
      ext_ofs     <= ext_ofs_next;
      body_seen   <= body_seen_next;
      body_ofs    <= body_ofs_next;
      body_lines  <= body_lines_next;
      ovf         <= ovf_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    step && last |=> mode == M_NORMAL && byte_offset == '0 && !ver_seen && !body_seen)
    else $error("scan state not cleared after final byte");

  assert property (@(posedge clk) disable iff (rst)
    byte_offset <= OFS_W'(MAX_TEXT))
    else $error("byte offset past saturation");

  assert property (@(posedge clk) disable iff (rst)
    (kw_idx != 4'd0) |-> (mode == M_KEYWORD && kind != K_NONE))
    else $error("keyword index live outside keyword match");

endmodule

// File: sv/shdl_result_reg.sv
// Result register: holds one finished result until the receiver takes it.
module shdl_result_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  shdl_pkg::result_item_t load_data,
  output logic                   can_load,
  shdl_stream_if.source          result
);
  import shdl_pkg::*;

  logic         valid;
  result_item_t data;

  assign can_load     = !valid || result.ready;
  assign result.valid = valid;
  assign result.data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

// File: sv/shader_header_directive_locator.sv
// Top level of the shader header directive locator.
// Usage:
//   text   - sink channel, one request per source byte: char_byte and last_byte,
//            last_byte high on the final byte of the text.
//   result - source channel, one request per text: version/extension directive
//            offsets, body offset, newline count before the body, overflow flag.
// Throughput: one byte per cycle, sustained, except while a final byte waits on a full result register.
// Flow: a taken byte is registered in the input register, then scanned; the
//   result of a final byte is loaded into the result register as it is scanned.
// The scan state advances by one short combinational pass per byte between the
//   input register and the scanner/result registers.
// Stall: bytes that are not final keep flowing while a result waits; a final
//   byte holds in the input register until the result register frees, and text
//   then deasserts ready until it moves.
// Reset (rst, synchronous): clears the scan state, the input register and the
//   result register. Scan state also returns to its reset values after every
//   final byte, so the next text starts fresh.
// Texts longer than MAX_TEXT bytes set too_long; offsets saturate at 65535.
module shader_header_directive_locator #(
  parameter int MAX_TEXT = 65536
) (
  input  logic          clk,
  input  logic          rst,
  shdl_stream_if.sink   text,
  shdl_stream_if.source result
);
  import shdl_pkg::*;

  logic         s1_valid;
  text_item_t   s1_item;
  logic         step;
  logic         can_load;
  result_item_t res;

  assign step       = s1_valid && (!s1_item.last_byte || can_load);
  assign text.ready = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.ready && text.valid) begin
      s1_item <= text.data;
    end
  end

  shdl_scanner #(
    .MAX_TEXT (MAX_TEXT)
  ) u_scanner (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (s1_item),
    .res  (res)
  );

  shdl_result_reg u_result_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step && s1_item.last_byte),
    .load_data (res),
    .can_load  (can_load),
    .result    (result)
  );

  assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready && s1_valid && s1_item.last_byte |-> !step)
    else $error("final byte scanned while result register full");

endmodule
